// File: rtl/fwsd_pkg.sv
// fwsd_pkg: types, register indexes, fixed-point constants and tables for the
// four-wheel steer and drive controller
// no dependencies
package fwsd_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TYRE = 3'd5;

    localparam logic [15:0] RST_GAIN_P = 16'd2048;
    localparam logic [15:0] RST_GAIN_D = 16'd0;
    localparam logic [14:0] RST_MAX_SPEED = 15'd1638;
    localparam logic [15:0] RST_TRACK = 16'd983;
    localparam logic [15:0] RST_AXLE = 16'd1229;
    localparam logic [15:0] RST_TYRE = 16'd573;

    // cordic: angle in 2^-16 rad, vectors in Q16
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_W = 20;
    localparam int ZIN_W = 19;
    localparam int CORDIC_LAT = CORDIC_STEPS + 2;
    localparam logic signed [CORDIC_W-1:0] CORDIC_K = 20'sd39797;
    localparam logic signed [CORDIC_W-1:0] ANG_PI = 20'sd205887;
    localparam logic signed [CORDIC_W-1:0] ANG_HALF_PI = 20'sd102944;

    // square root and divide
    localparam int SQRT_IN_W = 64;
    localparam int SQRT_OUT_W = 32;
    localparam int SQRT_LAT = SQRT_OUT_W;
    localparam int DIV_STEPS = 25;

    localparam logic signed [23:0] OUT_MAX = 24'sd8388607;
    localparam logic signed [23:0] OUT_MIN = -24'sd8388608;

    function automatic logic signed [CORDIC_W-1:0] atan_step(input int i);
        logic signed [CORDIC_W-1:0] a;
        case (i)
            0: a = 20'sd51472;
            1: a = 20'sd30386;
            2: a = 20'sd16055;
            3: a = 20'sd8150;
            4: a = 20'sd4091;
            5: a = 20'sd2047;
            6: a = 20'sd1024;
            7: a = 20'sd512;
            8: a = 20'sd256;
            9: a = 20'sd128;
            10: a = 20'sd64;
            11: a = 20'sd32;
            12: a = 20'sd16;
            13: a = 20'sd8;
            14: a = 20'sd4;
            15: a = 20'sd2;
            default: a = 20'sd0;
        endcase
        return a;
    endfunction

    typedef struct packed {
        logic signed [15:0] speed_cmd;
        logic signed [15:0] front_target;
        logic signed [15:0] rear_target;
        logic signed [15:0] angle_fl;
        logic signed [15:0] angle_fr;
        logic signed [15:0] angle_rl;
        logic signed [15:0] angle_rr;
        logic signed [15:0] rate_fl;
        logic signed [15:0] rate_fr;
        logic signed [15:0] rate_rl;
        logic signed [15:0] rate_rr;
    } cmd_t;

    typedef struct packed {
        logic signed [23:0] steer_drive_fl;
        logic signed [23:0] steer_drive_fr;
        logic signed [23:0] steer_drive_rl;
        logic signed [23:0] steer_drive_rr;
        logic signed [23:0] axle_rate_fl;
        logic signed [23:0] axle_rate_fr;
        logic signed [23:0] axle_rate_rl;
        logic signed [23:0] axle_rate_rr;
        logic saturated;
    } res_t;

endpackage

// File: rtl/fwsd_cordic.sv
// fwsd_cordic: pipelined rotation cordic giving cos and sin of one angle
// depends on fwsd_pkg
module fwsd_cordic (
    input  logic clk,
    input  logic en,
    input  logic signed [fwsd_pkg::ZIN_W-1:0] z,
    output logic signed [fwsd_pkg::CORDIC_W-1:0] cos_q,
    output logic signed [fwsd_pkg::CORDIC_W-1:0] sin_q
);

    localparam int N = fwsd_pkg::CORDIC_STEPS;
    localparam int W = fwsd_pkg::CORDIC_W;

    logic signed [W-1:0] x_reg [0:N];
    logic signed [W-1:0] y_reg [0:N];
    logic signed [W-1:0] z_reg [0:N];
    logic flip_reg [0:N];
    logic signed [W-1:0] z_ext;
    logic signed [W-1:0] cos_reg;
    logic signed [W-1:0] sin_reg;

    assign z_ext = W'(z);

    // fold into +-pi/2, results negated at the end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= fwsd_pkg::CORDIC_K;
            y_reg[0] <= '0;
            if (z_ext > fwsd_pkg::ANG_HALF_PI)
            begin
                z_reg[0] <= z_ext - fwsd_pkg::ANG_PI;
                flip_reg[0] <= 1'b1;
            end
            else if (z_ext < -fwsd_pkg::ANG_HALF_PI)
            begin
                z_reg[0] <= z_ext + fwsd_pkg::ANG_PI;
                flip_reg[0] <= 1'b1;
            end
            else
            begin
                z_reg[0] <= z_ext;
                flip_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - fwsd_pkg::atan_step(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + fwsd_pkg::atan_step(i);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= flip_reg[N] ? -x_reg[N] : x_reg[N];
            sin_reg <= flip_reg[N] ? -y_reg[N] : y_reg[N];
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

// File: rtl/fwsd_isqrt.sv
// fwsd_isqrt: pipelined floor integer square root, one result bit per stage
// depends on fwsd_pkg
module fwsd_isqrt (
    input  logic clk,
    input  logic en,
    input  logic [fwsd_pkg::SQRT_IN_W-1:0] v,
    output logic [fwsd_pkg::SQRT_OUT_W-1:0] root
);

    localparam int IW = fwsd_pkg::SQRT_IN_W;
    localparam int OW = fwsd_pkg::SQRT_OUT_W;
    localparam int RW = OW + 2;

    logic [RW-1:0] rem_reg [0:OW-1];
    logic [OW-1:0] root_reg [0:OW-1];
    logic [IW-1:0] v_reg [0:OW-1];

    for (genvar k = 0; k < OW; k++)
    begin : g_step
        logic [RW-1:0] rem_prev;
        logic [OW-1:0] root_prev;
        logic [IW-1:0] v_prev;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;

        if (k == 0)
        begin : g_first
            assign rem_prev = '0;
            assign root_prev = '0;
            assign v_prev = v;
        end
        else
        begin : g_next
            assign rem_prev = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign v_prev = v_reg[k-1];
        end

        assign rem_sh = {rem_prev[RW-3:0], v_prev[IW-1 -: 2]};
        assign trial = {root_prev, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k] <= {v_prev[IW-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg[k] <= rem_sh - trial;
                    root_reg[k] <= {root_prev[OW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= rem_sh;
                    root_reg[k] <= {root_prev[OW-2:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[OW-1];

endmodule

// File: rtl/four_wheel_steer_drive_controller.sv
// four_wheel_steer_drive_controller: top level, pd steering rates and
// ackermann wheel speeds; depends on fwsd_pkg, fwsd_cordic, fwsd_isqrt
//
// Fully pipelined: a new control update is taken in every cycle in which the
// result side is not stalled. The pipeline holds the 18-stage cordic, the
// 32-stage square roots and the 25-stage restoring divider; a stall on the
// result side freezes the whole pipeline and holds the output register.
module four_wheel_steer_drive_controller (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  fwsd_pkg::cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output fwsd_pkg::res_t res,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [fwsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fwsd_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int ST_CS = 1 + fwsd_pkg::CORDIC_LAT;
    localparam int ST_SUM = ST_CS + 6;
    localparam int ST_ROOT = ST_SUM + fwsd_pkg::SQRT_LAT;
    localparam int ST_MUL = ST_ROOT + 1;
    localparam int ST_DIV0 = ST_MUL + 2;
    localparam int ST_Q = ST_DIV0 + fwsd_pkg::DIV_STEPS;
    localparam int ST_OUT = ST_Q + 1;
    localparam int QW = fwsd_pkg::DIV_STEPS;

    // configuration
    logic [15:0] gain_p_reg, gain_d_reg, track_reg, axle_reg, tyre_reg;
    logic [14:0] max_speed_reg;
    logic [15:0] rad;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= fwsd_pkg::RST_GAIN_P;
            gain_d_reg <= fwsd_pkg::RST_GAIN_D;
            max_speed_reg <= fwsd_pkg::RST_MAX_SPEED;
            track_reg <= fwsd_pkg::RST_TRACK;
            axle_reg <= fwsd_pkg::RST_AXLE;
            tyre_reg <= fwsd_pkg::RST_TYRE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fwsd_pkg::REG_GAIN_P: gain_p_reg <= cfg_data;
                fwsd_pkg::REG_GAIN_D: gain_d_reg <= cfg_data;
                fwsd_pkg::REG_MAX_SPEED: max_speed_reg <= cfg_data[14:0];
                fwsd_pkg::REG_TRACK: track_reg <= cfg_data;
                fwsd_pkg::REG_AXLE: axle_reg <= cfg_data;
                fwsd_pkg::REG_TYRE: tyre_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign rad = (tyre_reg == 16'd0) ? 16'd1 : tyre_reg;

    // pipeline control
    logic adv;
    logic [ST_OUT:0] vld_reg;

    assign res_valid = vld_reg[ST_OUT];
    assign adv = !(res_valid && res_stall);
    assign cmd_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[ST_OUT-1:0], cmd_valid};
    end

    // stage 0: input register
    fwsd_pkg::cmd_t in_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            in_reg <= cmd;
    end

    // stage 1: speed clamp, angle sums, steering errors
    logic signed [16:0] ms17, sp17, spd_c;
    logic signed [16:0] sf, sr;
    logic signed [17:0] p_sum, q_dif;
    logic [14:0] mag_reg [1:ST_ROOT];
    logic neg_reg [1:ST_Q];
    logic pzero_reg [1:ST_ROOT];
    logic signed [fwsd_pkg::ZIN_W-1:0] zp_reg, zq_reg;
    logic signed [16:0] diff_reg [4];
    logic signed [15:0] rate_reg [4];
    logic signed [15:0] ang [4];
    logic signed [15:0] rte [4];

    assign ang[0] = in_reg.angle_fl;
    assign ang[1] = in_reg.angle_fr;
    assign ang[2] = in_reg.angle_rl;
    assign ang[3] = in_reg.angle_rr;
    assign rte[0] = in_reg.rate_fl;
    assign rte[1] = in_reg.rate_fr;
    assign rte[2] = in_reg.rate_rl;
    assign rte[3] = in_reg.rate_rr;

    always_comb
    begin
        ms17 = $signed({2'b00, max_speed_reg});
        sp17 = 17'(in_reg.speed_cmd);
        if (sp17 > ms17)
            spd_c = ms17;
        else if (sp17 < -ms17)
            spd_c = -ms17;
        else
            spd_c = sp17;
        sf = 17'(in_reg.angle_fl) + 17'(in_reg.angle_fr);
        sr = 17'(in_reg.angle_rl) + 17'(in_reg.angle_rr);
        p_sum = 18'(sr) + 18'(sf);
        q_dif = 18'(sr) - 18'(sf);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg[1] <= spd_c[16] ? 15'(-spd_c) : spd_c[14:0];
            neg_reg[1] <= spd_c[16];
            pzero_reg[1] <= (p_sum == 18'sd0);
            zp_reg <= {p_sum, 1'b0};
            zq_reg <= {q_dif, 1'b0};
            for (int k = 0; k < 4; k++)
            begin
                diff_reg[k] <= (k < 2 ? 17'(in_reg.front_target) : 17'(in_reg.rear_target))
                               - 17'(ang[k]);
                rate_reg[k] <= rte[k];
            end
            for (int s = 2; s <= ST_ROOT; s++)
            begin
                mag_reg[s] <= mag_reg[s-1];
                pzero_reg[s] <= pzero_reg[s-1];
            end
            for (int s = 2; s <= ST_Q; s++)
                neg_reg[s] <= neg_reg[s-1];
        end
    end

    // stages 2 and 3: steering pd law
    logic signed [33:0] prodp_reg [4];
    logic signed [32:0] prodd_reg [4];
    logic signed [23:0] steer_reg [3:ST_Q][4];
    logic steer_sat_reg [3:ST_Q];
    logic signed [23:0] steer_next [4];
    logic steer_sat_next;
    logic signed [37:0] pd_v;
    logic signed [37:0] pd_r;

    always_comb
    begin
        steer_sat_next = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            pd_v = 38'(prodp_reg[k]) - (38'(prodd_reg[k]) <<< 4);
            pd_r = (pd_v + 38'sd128) >>> 8;
            if (pd_r > 38'(fwsd_pkg::OUT_MAX))
            begin
                steer_next[k] = fwsd_pkg::OUT_MAX;
                steer_sat_next = 1'b1;
            end
            else if (pd_r < 38'(fwsd_pkg::OUT_MIN))
            begin
                steer_next[k] = fwsd_pkg::OUT_MIN;
                steer_sat_next = 1'b1;
            end
            else
                steer_next[k] = pd_r[23:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                prodp_reg[k] <= $signed({1'b0, gain_p_reg}) * diff_reg[k];
                prodd_reg[k] <= $signed({1'b0, gain_d_reg}) * rate_reg[k];
            end
            steer_reg[3] <= steer_next;
            steer_sat_reg[3] <= steer_sat_next;
            for (int s = 4; s <= ST_Q; s++)
            begin
                steer_reg[s] <= steer_reg[s-1];
                steer_sat_reg[s] <= steer_sat_reg[s-1];
            end
        end
    end

    // cos and sin of r+f and r-f
    logic signed [fwsd_pkg::CORDIC_W-1:0] cp, sp, cq, sq;

    fwsd_cordic u_cordic_p (
        .clk   (clk),
        .en    (adv),
        .z     (zp_reg),
        .cos_q (cp),
        .sin_q (sp)
    );

    fwsd_cordic u_cordic_q (
        .clk   (clk),
        .en    (adv),
        .z     (zq_reg),
        .cos_q (cq),
        .sin_q (sq)
    );

    // turn centre geometry: products, vector components, squares
    logic signed [20:0] sumc_reg;
    logic signed [fwsd_pkg::CORDIC_W-1:0] sq1_reg, sp1_reg;
    logic signed [35:0] x_reg, y_reg, b_reg, a_reg;
    logic signed [36:0] x_full, b_full, a_full;
    logic signed [37:0] y_full;
    logic signed [35:0] ca_reg [5];
    logic signed [35:0] cb_reg [5];
    logic [31:0] ma_reg [5];
    logic [31:0] mb_reg [5];
    logic [63:0] sqa_reg [5];
    logic [63:0] sqb_reg [5];
    logic [63:0] sum_reg [5];
    logic [31:0] ma_next [5];
    logic [31:0] mb_next [5];
    logic signed [31:0] sha, shb;

    always_comb
    begin
        x_full = sq1_reg * $signed({1'b0, axle_reg});
        y_full = sumc_reg * $signed({1'b0, axle_reg});
        b_full = sp1_reg * $signed({1'b0, axle_reg});
        a_full = sp1_reg * $signed({1'b0, track_reg});
        for (int j = 0; j < 5; j++)
        begin
            sha = ca_reg[j][35:4];
            shb = cb_reg[j][35:4];
            ma_next[j] = sha[31] ? 32'(-sha) : sha;
            mb_next[j] = shb[31] ? 32'(-shb) : shb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sumc_reg <= 21'(cq) + 21'(cp);
            sq1_reg <= sq;
            sp1_reg <= sp;
            x_reg <= x_full[35:0];
            y_reg <= y_full[35:0];
            b_reg <= b_full[35:0];
            a_reg <= a_full[35:0];
            // centre distance, then fl, fr, rl, rr
            ca_reg[0] <= x_reg;
            cb_reg[0] <= y_reg;
            ca_reg[1] <= x_reg - b_reg;
            cb_reg[1] <= y_reg - a_reg;
            ca_reg[2] <= x_reg - b_reg;
            cb_reg[2] <= y_reg + a_reg;
            ca_reg[3] <= x_reg + b_reg;
            cb_reg[3] <= y_reg - a_reg;
            ca_reg[4] <= x_reg + b_reg;
            cb_reg[4] <= y_reg + a_reg;
            for (int j = 0; j < 5; j++)
            begin
                ma_reg[j] <= ma_next[j];
                mb_reg[j] <= mb_next[j];
                sqa_reg[j] <= ma_reg[j] * ma_reg[j];
                sqb_reg[j] <= mb_reg[j] * mb_reg[j];
                sum_reg[j] <= sqa_reg[j] + sqb_reg[j];
            end
        end
    end

    logic [fwsd_pkg::SQRT_OUT_W-1:0] root [5];

    for (genvar j = 0; j < 5; j++)
    begin : g_sqrt
        fwsd_isqrt u_isqrt (
            .clk  (clk),
            .en   (adv),
            .v    (sum_reg[j]),
            .root (root[j])
        );
    end

    // divider setup: numerator and divisor for round-to-nearest
    logic fallback;
    logic [31:0] den_eff;
    logic [46:0] m_reg [4];
    logic [47:0] dd_reg;
    logic [60:0] n_reg [4];
    logic [48:0] dsh_reg [ST_MUL+1:ST_Q];
    logic [60:0] rem_reg [ST_DIV0:ST_Q][4];
    logic [QW-1:0] q_reg [ST_DIV0:ST_Q][4];
    logic ovf_reg [ST_DIV0:ST_Q][4];

    // opposite mean angles or zero centre distance: ratios of one
    assign fallback = pzero_reg[ST_ROOT] || (root[0] == '0);
    assign den_eff = fallback ? 32'd1 : root[0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                m_reg[k] <= mag_reg[ST_ROOT] * (fallback ? 32'd1 : root[k+1]);
                n_reg[k] <= {1'b0, m_reg[k], 13'b0} + 61'(dd_reg);
                ovf_reg[ST_DIV0][k] <= {13'b0, n_reg[k]} >= {dsh_reg[ST_MUL+1], 25'b0};
                rem_reg[ST_DIV0][k] <= n_reg[k];
                q_reg[ST_DIV0][k] <= '0;
            end
            dd_reg <= den_eff * rad;
            dsh_reg[ST_MUL+1] <= {dd_reg, 1'b0};
            for (int s = ST_MUL + 2; s <= ST_Q; s++)
                dsh_reg[s] <= dsh_reg[s-1];
        end
    end

    // restoring divide, one quotient bit per stage, msb first
    for (genvar s = ST_DIV0 + 1; s <= ST_Q; s++)
    begin : g_div
        localparam int B = ST_Q - s;
        logic [73:0] trial;

        assign trial = {25'b0, dsh_reg[s-1]} << B;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    ovf_reg[s][k] <= ovf_reg[s-1][k];
                    if ({13'b0, rem_reg[s-1][k]} >= trial)
                    begin
                        rem_reg[s][k] <= rem_reg[s-1][k] - trial[60:0];
                        q_reg[s][k] <= {q_reg[s-1][k][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[s][k] <= rem_reg[s-1][k];
                        q_reg[s][k] <= {q_reg[s-1][k][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // output register: sign, saturation, flag
    logic signed [23:0] axle_next [4];
    logic axle_sat_next;
    logic lane_sat;
    fwsd_pkg::res_t res_reg;

    always_comb
    begin
        axle_sat_next = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            lane_sat = ovf_reg[ST_Q][k]
                       || (neg_reg[ST_Q] ? (q_reg[ST_Q][k] > 25'd8388608)
                                         : (q_reg[ST_Q][k] > 25'd8388607));
            if (lane_sat)
                axle_next[k] = neg_reg[ST_Q] ? fwsd_pkg::OUT_MIN : fwsd_pkg::OUT_MAX;
            else if (neg_reg[ST_Q])
                axle_next[k] = 24'(-q_reg[ST_Q][k]);
            else
                axle_next[k] = q_reg[ST_Q][k][23:0];
            axle_sat_next = axle_sat_next | lane_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg.steer_drive_fl <= steer_reg[ST_Q][0];
            res_reg.steer_drive_fr <= steer_reg[ST_Q][1];
            res_reg.steer_drive_rl <= steer_reg[ST_Q][2];
            res_reg.steer_drive_rr <= steer_reg[ST_Q][3];
            res_reg.axle_rate_fl <= axle_next[0];
            res_reg.axle_rate_fr <= axle_next[1];
            res_reg.axle_rate_rl <= axle_next[2];
            res_reg.axle_rate_rr <= axle_next[3];
            res_reg.saturated <= steer_sat_reg[ST_Q] | axle_sat_next;
        end
    end

    assign res = res_reg;

endmodule

// File: tb/sv/tb.sv
// tb: self-checking testbench for four_wheel_steer_drive_controller
// predicts pd steering rates and wheel-axle rates per control update and checks each result
// depends on fwsd_pkg and the rtl of the controller
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    fwsd_pkg::cmd_t cmd;
    logic res_valid;
    logic res_stall;
    fwsd_pkg::res_t res;
    logic cfg_valid;
    logic cfg_ready;
    logic [fwsd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [fwsd_pkg::CFG_DATA_W-1:0] cfg_data;

    four_wheel_steer_drive_controller i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // shadow copy of the register file
    longint gain_p_sh;
    longint gain_d_sh;
    longint max_speed_sh;
    longint track_sh;
    longint axle_sh;
    longint tyre_sh;

    fwsd_pkg::cmd_t pending_cmds[$];
    fwsd_pkg::res_t expected_res[$];
    int mismatches;
    int sender_idle_pct;
    int receiver_idle_pct;
    bit cmd_fired;
    bit hold_go;
    bit hold_done;
    int hold_left;
    int quiet_cycles;

    function automatic logic [23:0] clip24(input longint v, inout bit flag);
        if (v > 64'sd8388607)
        begin
            v = 64'sd8388607;
            flag = 1'b1;
        end
        if (v < -64'sd8388608)
        begin
            v = -64'sd8388608;
            flag = 1'b1;
        end
        return v[23:0];
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned span(input longint a, input longint b);
        longint sa;
        longint sb;
        sa = a >>> 4;
        sb = b >>> 4;
        return root64(longint'(sa * sa) + longint'(sb * sb));
    endfunction

    // round to nearest, ties away from zero
    function automatic longint round_div(input longint n, input longint unsigned d);
        longint unsigned mag;
        longint unsigned q;
        mag = (n < 0) ? longint'(-n) : n;
        q = (2 * mag + d) / (2 * d);
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    task automatic rotate(input longint z, output longint c, output longint s);
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit flip;
        x = fwsd_pkg::CORDIC_K;
        y = 0;
        flip = 0;
        if (z > fwsd_pkg::ANG_HALF_PI)
        begin
            z = z - fwsd_pkg::ANG_PI;
            flip = 1;
        end
        else if (z < -fwsd_pkg::ANG_HALF_PI)
        begin
            z = z + fwsd_pkg::ANG_PI;
            flip = 1;
        end
        for (int i = 0; i < fwsd_pkg::CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - fwsd_pkg::atan_step(i);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + fwsd_pkg::atan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_drive(input fwsd_pkg::cmd_t c, output fwsd_pkg::res_t r);
        longint speed;
        longint ang[4];
        longint rate[4];
        longint tgt;
        longint v;
        longint p;
        longint q;
        longint cp;
        longint sp;
        longint cq;
        longint sq;
        longint xx;
        longint yy;
        longint bb;
        longint aa;
        longint unsigned den;
        longint unsigned num;
        longint unsigned rad;
        logic [23:0] drive[4];
        logic [23:0] axle[4];
        bit flag;
        bit ratios;
        flag = 0;
        ratios = 0;
        speed = c.speed_cmd;
        ang[0] = c.angle_fl;
        ang[1] = c.angle_fr;
        ang[2] = c.angle_rl;
        ang[3] = c.angle_rr;
        rate[0] = c.rate_fl;
        rate[1] = c.rate_fr;
        rate[2] = c.rate_rl;
        rate[3] = c.rate_rr;
        rad = (tyre_sh == 0) ? 1 : tyre_sh;
        // speed clamp does not flag saturation
        if (speed > max_speed_sh)
            speed = max_speed_sh;
        else if (speed < -max_speed_sh)
            speed = -max_speed_sh;
        for (int k = 0; k < 4; k++)
        begin
            tgt = (k < 2) ? longint'(c.front_target) : longint'(c.rear_target);
            v = gain_p_sh * (tgt - ang[k]) - gain_d_sh * rate[k] * 16;
            drive[k] = clip24((v + 128) >>> 8, flag);
        end
        p = (ang[2] + ang[3]) + (ang[0] + ang[1]);
        q = (ang[2] + ang[3]) - (ang[0] + ang[1]);
        if (p != 0)
        begin
            rotate(p * 2, cp, sp);
            rotate(q * 2, cq, sq);
            xx = sq * axle_sh;
            yy = (cq + cp) * axle_sh;
            bb = sp * axle_sh;
            aa = sp * track_sh;
            den = span(xx, yy);
            if (den != 0)
            begin
                ratios = 1;
                axle[0] = clip24(round_div(speed * longint'(span(xx - bb, yy - aa)) * 4096,
                    den * rad), flag);
                axle[1] = clip24(round_div(speed * longint'(span(xx - bb, yy + aa)) * 4096,
                    den * rad), flag);
                axle[2] = clip24(round_div(speed * longint'(span(xx + bb, yy - aa)) * 4096,
                    den * rad), flag);
                axle[3] = clip24(round_div(speed * longint'(span(xx + bb, yy + aa)) * 4096,
                    den * rad), flag);
            end
        end
        // opposite mean angles or zero centre distance: plain speed over radius
        if (!ratios)
            for (int k = 0; k < 4; k++)
                axle[k] = clip24(round_div(speed * 4096, rad), flag);
        r.steer_drive_fl = drive[0];
        r.steer_drive_fr = drive[1];
        r.steer_drive_rl = drive[2];
        r.steer_drive_rr = drive[3];
        r.axle_rate_fl = axle[0];
        r.axle_rate_fr = axle[1];
        r.axle_rate_rl = axle[2];
        r.axle_rate_rr = axle[3];
        r.saturated = flag;
    endtask

    function automatic logic [15:0] pick_angle(input bit full);
        if (full)
            return 16'($urandom);
        return 16'($urandom_range(0, 16000) - 8000);
    endfunction

    // mostly plausible steering geometry, some full-range noise
    function automatic fwsd_pkg::cmd_t random_cmd();
        fwsd_pkg::cmd_t c;
        int kind;
        bit full;
        kind = $urandom_range(0, 99);
        full = (kind < 25);
        c.speed_cmd = full ? 16'($urandom) : 16'($urandom_range(0, 8000) - 4000);
        c.front_target = pick_angle(full);
        c.rear_target = pick_angle(full);
        c.angle_fl = pick_angle(full);
        c.angle_fr = pick_angle(full);
        c.angle_rl = pick_angle(full);
        c.angle_rr = pick_angle(full);
        c.rate_fl = full ? 16'($urandom) : 16'($urandom_range(0, 2000) - 1000);
        c.rate_fr = full ? 16'($urandom) : 16'($urandom_range(0, 2000) - 1000);
        c.rate_rl = full ? 16'($urandom) : 16'($urandom_range(0, 2000) - 1000);
        c.rate_rr = full ? 16'($urandom) : 16'($urandom_range(0, 2000) - 1000);
        if (kind >= 90)
        begin
            // opposite mean angles
            c.angle_rl = -c.angle_fl;
            c.angle_rr = -c.angle_fr;
        end
        return c;
    endfunction

    function automatic fwsd_pkg::cmd_t fill_cmd(input logic [15:0] sp, input logic [15:0] ang,
                                                input logic [15:0] tg, input logic [15:0] rt);
        fwsd_pkg::cmd_t c;
        c.speed_cmd = sp;
        c.front_target = tg;
        c.rear_target = ~tg;
        c.angle_fl = ang;
        c.angle_fr = ang;
        c.angle_rl = ang;
        c.angle_rr = ang;
        c.rate_fl = rt;
        c.rate_fr = rt;
        c.rate_rl = ~rt;
        c.rate_rr = rt;
        return c;
    endfunction

    task automatic write_reg(input logic [fwsd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        case (idx)
            fwsd_pkg::REG_GAIN_P: gain_p_sh = val;
            fwsd_pkg::REG_GAIN_D: gain_d_sh = val;
            fwsd_pkg::REG_MAX_SPEED: max_speed_sh = val[14:0];
            fwsd_pkg::REG_TRACK: track_sh = val;
            fwsd_pkg::REG_AXLE: axle_sh = val;
            fwsd_pkg::REG_TYRE: tyre_sh = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_geometry(input logic [15:0] gp, input logic [15:0] gd,
                                input logic [15:0] ms, input logic [15:0] tw,
                                input logic [15:0] ax, input logic [15:0] ty);
        while (pending_cmds.size() != 0 || expected_res.size() != 0 || cmd_valid)
            @(negedge clk);
        repeat (100) @(negedge clk);
        write_reg(fwsd_pkg::REG_GAIN_P, gp);
        write_reg(fwsd_pkg::REG_GAIN_D, gd);
        write_reg(fwsd_pkg::REG_MAX_SPEED, ms);
        write_reg(fwsd_pkg::REG_TRACK, tw);
        write_reg(fwsd_pkg::REG_AXLE, ax);
        write_reg(fwsd_pkg::REG_TYRE, ty);
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            pending_cmds.push_back(random_cmd());
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // command driver
    always @(negedge clk)
    begin
        if (!cmd_valid || cmd_fired)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                cmd <= pending_cmds.pop_front();
                cmd_valid <= 1'b1;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // result side stall, with one long hold-off
    always @(negedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            if (hold_left == 0)
                hold_left <= HOLD_CYCLES;
            else if (hold_left == 1)
                hold_done <= 1'b1;
            else
                hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end

    // monitor, prediction and watchdog
    always @(posedge clk)
    begin
        fwsd_pkg::res_t want;
        fwsd_pkg::res_t got;
        cmd_fired = cmd_valid && !cmd_stall && rst_n;
        if (cmd_fired)
        begin
            predict_drive(cmd, want);
            expected_res.push_back(want);
        end
        if (rst_n && res_valid && !res_stall)
        begin
            got = res;
            if (expected_res.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %h", got);
            end
            else
            begin
                want = expected_res.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h %h %h %h | %h %h %h %h | %b,",
                            want.steer_drive_fl, want.steer_drive_fr, want.steer_drive_rl,
                            want.steer_drive_rr, want.axle_rate_fl, want.axle_rate_fr,
                            want.axle_rate_rl, want.axle_rate_rr, want.saturated,
                            " got %h %h %h %h | %h %h %h %h | %b",
                            got.steer_drive_fl, got.steer_drive_fr, got.steer_drive_rl,
                            got.steer_drive_rr, got.axle_rate_fl, got.axle_rate_fr,
                            got.axle_rate_rl, got.axle_rate_rr, got.saturated);
                end
            end
        end
        if (cmd_fired || (res_valid && !res_stall) || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        res_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        cmd_fired = 0;
        hold_go = 0;
        hold_done = 0;
        hold_left = 0;
        quiet_cycles = 0;
        gain_p_sh = fwsd_pkg::RST_GAIN_P;
        gain_d_sh = fwsd_pkg::RST_GAIN_D;
        max_speed_sh = fwsd_pkg::RST_MAX_SPEED;
        track_sh = fwsd_pkg::RST_TRACK;
        axle_sh = fwsd_pkg::RST_AXLE;
        tyre_sh = fwsd_pkg::RST_TYRE;
        sender_idle_pct = 13;
        receiver_idle_pct = 67;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (5) @(negedge clk);

        // directed part at reset values
        pending_cmds.push_back(fill_cmd(16'h7FFF, 16'h0000, 16'h7FFF, 16'h7FFF));
        pending_cmds.push_back(fill_cmd(16'h8000, 16'h8000, 16'h7FFF, 16'h8000));
        pending_cmds.push_back(fill_cmd(16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001));
        pending_cmds.push_back(fill_cmd(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        pending_cmds.push_back(fill_cmd(16'd1000, 16'd1000, 16'd500, 16'd100));
        pending_cmds.push_back(fill_cmd(-16'sd1000, -16'sd3000, 16'd0, -16'sd5));
        // mean angles near pi, centre distance close to zero
        pending_cmds.push_back(fill_cmd(16'd1200, 16'd25736, 16'd0, 16'd0));
        pending_cmds.push_back(fill_cmd(16'd1200, -16'sd25736, 16'd0, 16'd0));
        pending_cmds.push_back(fill_cmd(16'd1200, 16'd25735, 16'd0, 16'd0));
        queue_random(11);
        set_geometry(fwsd_pkg::RST_GAIN_P, 16'd0, 16'(fwsd_pkg::RST_MAX_SPEED),
            fwsd_pkg::RST_TRACK, fwsd_pkg::RST_AXLE, fwsd_pkg::RST_TYRE);
        // ignored register indexes
        write_reg(3'd6, 16'hFFFF);
        write_reg(3'd7, 16'h1234);
        pending_cmds.push_back(fill_cmd(16'h7FFF, 16'h5555, 16'hAAAA, 16'h5555));
        queue_random(150);

        // upper extremes, max_speed write masked
        set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        pending_cmds.push_back(fill_cmd(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        queue_random(160);

        sender_idle_pct = 67;
        receiver_idle_pct = 13;
        // lower extremes, tyre radius zero
        set_geometry(16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0);
        queue_random(80);
        set_geometry(16'd64, 16'd0, 16'h7FFF, 16'd1, 16'd1, 16'd0);
        queue_random(80);
        set_geometry(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)),
            16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        queue_random(170);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        set_geometry(16'd256, 16'd64, 16'h7FFF, fwsd_pkg::RST_TRACK, fwsd_pkg::RST_AXLE,
            16'd1);
        hold_go = 1;
        queue_random(170);
        set_geometry(16'($urandom), 16'($urandom_range(0, 2000)), 16'($urandom_range(0, 32767)),
            16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000)),
            16'($urandom_range(1, 2000)));
        queue_random(170);

        while (pending_cmds.size() != 0 || expected_res.size() != 0 || cmd_valid)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (mismatches == 0 && expected_res.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// File: files.f
rtl/fwsd_pkg.sv
rtl/fwsd_cordic.sv
rtl/fwsd_isqrt.sv
rtl/four_wheel_steer_drive_controller.sv
tb/sv/tb.sv
